>>> hdl/bbc_pkg.sv
package bbc_pkg;

    // field widths fixed by the word formats
    localparam int CHAN_W   = 8;
    localparam int CFG_W_W  = 11;
    localparam int CFG_H_W  = 13;
    localparam int CFG_D_W  = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CSUM_W   = 10;   // one window column, up to 3 pixels
    localparam int SUM_W    = 12;   // full window, up to 9 pixels
    localparam int CNT_W    = 4;    // pixel count, 1..9
    localparam int RECIP_W  = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int QUEUE_DEPTH = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 13'd1;

    // input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } t_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              frame_done;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_D_W-1:0]   data;
    } t_cfg_wr;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        logic [CSUM_W-1:0] r;
        logic [CSUM_W-1:0] g;
        logic [CSUM_W-1:0] b;
    } t_csum;

    // one averaging job handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic [CNT_W-1:0] count;
        logic             done;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_JOB1,
        S_JOB2
    } t_front_state;

    // ceil(2^16 / count); exact rounding division for sums below 2^15
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        unique case (count)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/bbc_fifo.sv
module bbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    // callers must never push into a full queue; a pop on empty is simply ignored
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("word pushed into full queue");
`endif

endmodule

>>> hdl/bbc_front.sv
module bbc_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bbc_pkg::t_cfg_wr i_cfg,
    input  logic             i_push,
    output logic             o_full,
    input  bbc_pkg::t_item   i_item,
    output logic             o_job_push,
    output bbc_pkg::t_job    o_job,
    input  logic             i_job_full
);

    localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);

    // control state
    bbc_pkg::t_front_state       r_state;
    bbc_pkg::t_front_state       n_state;
    logic [HW-1:0]               r_row;
    logic [HW-1:0]               n_row;
    logic [COLW-1:0]             r_col;
    logic [COLW-1:0]             n_col;
    logic [bbc_pkg::CFG_W_W-1:0] r_width;
    logic [bbc_pkg::CFG_H_W-1:0] r_height;

    // line buffers
    bbc_pkg::t_rgb mem_above [MAX_WIDTH];
    bbc_pkg::t_rgb mem_cur   [MAX_WIDTH];
    bbc_pkg::t_rgb r_rd_above;
    bbc_pkg::t_rgb r_rd_cur;
    bbc_pkg::t_rgb r_incoming;

    // window column sums, 0 oldest .. 2 newest
    bbc_pkg::t_csum r_csum [3];
    bbc_pkg::t_csum new_csum;
    logic           r_emit2;
    logic           r_three;
    logic           r_wide;
    logic [1:0]     r_nrows;
    logic           r_done;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          accept;
    logic          accept_item;
    logic          row_ge1;
    logic          row_ge2;
    logic          row_lt_h;
    logic          last_col;
    logic          emit1_now;
    logic          emit2_now;
    logic [1:0]    nrows;
    bbc_pkg::t_job job1;
    bbc_pkg::t_job job2;

    // clamp the size registers
    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_height);
        end
    end

    // position classification
    assign row_ge1  = (r_row != '0);
    assign row_ge2  = (r_row > HW'(1));
    assign row_lt_h = (r_row < h_eff);
    assign last_col = (WW'(r_col) == w_eff - WW'(1));
    assign emit1_now = row_ge1 && (r_col != '0);
    assign emit2_now = row_ge1 && last_col;
    assign nrows = 2'(row_ge2) + 2'd1 + 2'(row_lt_h);

    // input handshake; an early flush is taken and dropped
    assign o_full      = (r_state != bbc_pkg::S_IDLE);
    assign accept      = i_push && !o_full;
    assign accept_item = accept && !(i_item.cmd == bbc_pkg::CMD_FLUSH && row_lt_h);

    // next position
    always_comb begin
        if (last_col) begin
            n_col = '0;
            n_row = row_lt_h ? r_row + HW'(1) : '0;
        end else begin
            n_col = r_col + COLW'(1);
            n_row = r_row;
        end
    end

    // line buffers: read on accept, write back in the load cycle
    always_ff @(posedge i_clk) begin
        if (accept_item) begin
            r_rd_above <= mem_above[r_col];
            r_rd_cur   <= mem_cur[r_col];
        end
        if (r_state == bbc_pkg::S_LOAD) begin
            mem_above[r_col] <= r_rd_cur;
            mem_cur[r_col]   <= r_incoming;
        end
    end

    // newest column sum over the rows that exist
    always_comb begin
        new_csum.r = (row_ge2 ? bbc_pkg::CSUM_W'(r_rd_above.r) : '0)
                   + bbc_pkg::CSUM_W'(r_rd_cur.r) + bbc_pkg::CSUM_W'(r_incoming.r);
        new_csum.g = (row_ge2 ? bbc_pkg::CSUM_W'(r_rd_above.g) : '0)
                   + bbc_pkg::CSUM_W'(r_rd_cur.g) + bbc_pkg::CSUM_W'(r_incoming.g);
        new_csum.b = (row_ge2 ? bbc_pkg::CSUM_W'(r_rd_above.b) : '0)
                   + bbc_pkg::CSUM_W'(r_rd_cur.b) + bbc_pkg::CSUM_W'(r_incoming.b);
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept_item) begin
            if (row_lt_h) begin
                r_incoming <= '{r: i_item.red_in, g: i_item.green_in, b: i_item.blue_in};
            end else begin
                r_incoming <= '0;
            end
        end
        if (r_state == bbc_pkg::S_LOAD) begin
            r_csum[0] <= r_csum[1];
            r_csum[1] <= r_csum[2];
            r_csum[2] <= new_csum;
            r_emit2   <= emit2_now;
            r_three   <= (r_col > COLW'(1));
            r_wide    <= (w_eff > WW'(1));
            r_nrows   <= nrows;
            r_done    <= !row_lt_h;
        end
    end

    // control registers and configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bbc_pkg::S_IDLE;
            r_row    <= '0;
            r_col    <= '0;
            r_width  <= bbc_pkg::WIDTH_RESET;
            r_height <= bbc_pkg::HEIGHT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg.we) begin
                if (i_cfg.idx == bbc_pkg::CFG_FRAME_WIDTH) begin
                    r_width <= i_cfg.data[bbc_pkg::CFG_W_W-1:0];
                end else begin
                    r_height <= i_cfg.data[bbc_pkg::CFG_H_W-1:0];
                end
                r_row <= '0;
                r_col <= '0;
            end else if (r_state == bbc_pkg::S_LOAD) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    // window sums for the two possible jobs
    always_comb begin
        job1.sum_r = (r_three ? bbc_pkg::SUM_W'(r_csum[0].r) : '0)
                   + bbc_pkg::SUM_W'(r_csum[1].r) + bbc_pkg::SUM_W'(r_csum[2].r);
        job1.sum_g = (r_three ? bbc_pkg::SUM_W'(r_csum[0].g) : '0)
                   + bbc_pkg::SUM_W'(r_csum[1].g) + bbc_pkg::SUM_W'(r_csum[2].g);
        job1.sum_b = (r_three ? bbc_pkg::SUM_W'(r_csum[0].b) : '0)
                   + bbc_pkg::SUM_W'(r_csum[1].b) + bbc_pkg::SUM_W'(r_csum[2].b);
        job1.count = (r_three ? bbc_pkg::CNT_W'(3) : bbc_pkg::CNT_W'(2))
                   * bbc_pkg::CNT_W'(r_nrows);
        job1.done  = 1'b0;

        job2.sum_r = (r_wide ? bbc_pkg::SUM_W'(r_csum[1].r) : '0)
                   + bbc_pkg::SUM_W'(r_csum[2].r);
        job2.sum_g = (r_wide ? bbc_pkg::SUM_W'(r_csum[1].g) : '0)
                   + bbc_pkg::SUM_W'(r_csum[2].g);
        job2.sum_b = (r_wide ? bbc_pkg::SUM_W'(r_csum[1].b) : '0)
                   + bbc_pkg::SUM_W'(r_csum[2].b);
        job2.count = (r_wide ? bbc_pkg::CNT_W'(2) : bbc_pkg::CNT_W'(1))
                   * bbc_pkg::CNT_W'(r_nrows);
        job2.done  = r_done;
    end

    // sequencer: accept, load, then push up to two jobs
    always_comb begin
        n_state    = r_state;
        o_job_push = 1'b0;
        o_job      = job1;
        unique case (r_state)
            bbc_pkg::S_IDLE: begin
                if (accept_item) begin
                    n_state = bbc_pkg::S_LOAD;
                end
            end
            bbc_pkg::S_LOAD: begin
                if (emit1_now) begin
                    n_state = bbc_pkg::S_JOB1;
                end else if (emit2_now) begin
                    n_state = bbc_pkg::S_JOB2;
                end else begin
                    n_state = bbc_pkg::S_IDLE;
                end
            end
            bbc_pkg::S_JOB1: begin
                o_job_push = !i_job_full;
                if (!i_job_full) begin
                    n_state = r_emit2 ? bbc_pkg::S_JOB2 : bbc_pkg::S_IDLE;
                end
            end
            bbc_pkg::S_JOB2: begin
                o_job      = job2;
                o_job_push = !i_job_full;
                if (!i_job_full) begin
                    n_state = bbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bbc_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // position stays inside the frame plus the drain row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < w_eff)
        else $error("column beyond frame width");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h_eff)
        else $error("row beyond drain row");
`endif

endmodule

>>> hdl/bbc_back.sv
module bbc_back (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  bbc_pkg::t_job                             i_job,
    input  logic                                      i_job_valid,
    output logic                                      o_job_pop,
    input  logic [$clog2(bbc_pkg::QUEUE_DEPTH+1)-1:0] i_out_count,
    output logic                                      o_out_push,
    output bbc_pkg::t_result                          o_result
);

    localparam int CW = $clog2(bbc_pkg::QUEUE_DEPTH + 1);

    logic                        r_mul_valid;
    logic [bbc_pkg::PROD_W-1:0]  r_prod_r;
    logic [bbc_pkg::PROD_W-1:0]  r_prod_g;
    logic [bbc_pkg::PROD_W-1:0]  r_prod_b;
    logic                        r_done;
    logic [bbc_pkg::SUM_W-1:0]   half;
    logic [bbc_pkg::SUM_W-1:0]   x_r;
    logic [bbc_pkg::SUM_W-1:0]   x_g;
    logic [bbc_pkg::SUM_W-1:0]   x_b;
    logic [bbc_pkg::RECIP_W-1:0] m;

    // take a job only if the output queue has room for it and the one in flight
    assign o_job_pop = i_job_valid
        && ((CW + 1)'(i_out_count) + (CW + 1)'(r_mul_valid) < (CW + 1)'(bbc_pkg::QUEUE_DEPTH));

    // rounding bias and reciprocal of the pixel count
    always_comb begin
        half = bbc_pkg::SUM_W'(i_job.count >> 1);
        x_r  = i_job.sum_r + half;
        x_g  = i_job.sum_g + half;
        x_b  = i_job.sum_b + half;
        m    = bbc_pkg::recip(i_job.count);
    end

    // reciprocal multiply, one register stage
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_prod_r <= bbc_pkg::PROD_W'(x_r) * bbc_pkg::PROD_W'(m);
            r_prod_g <= bbc_pkg::PROD_W'(x_g) * bbc_pkg::PROD_W'(m);
            r_prod_b <= bbc_pkg::PROD_W'(x_b) * bbc_pkg::PROD_W'(m);
            r_done   <= i_job.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else begin
            r_mul_valid <= o_job_pop;
        end
    end

    // quotient is the product shifted down
    assign o_out_push          = r_mul_valid;
    assign o_result.red_out    = r_prod_r[bbc_pkg::RECIP_SHIFT +: bbc_pkg::CHAN_W];
    assign o_result.green_out  = r_prod_g[bbc_pkg::RECIP_SHIFT +: bbc_pkg::CHAN_W];
    assign o_result.blue_out   = r_prod_b[bbc_pkg::RECIP_SHIFT +: bbc_pkg::CHAN_W];
    assign o_result.frame_done = r_done;

`ifndef ASSERT_OFF
    // the word in flight always finds room in the output queue
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_valid |-> (i_out_count < CW'(bbc_pkg::QUEUE_DEPTH)))
        else $error("result word with no room in output queue");
`endif

endmodule

>>> hdl/box_blur_3x3_clamped.sv
// An accepted pixel's results pass the load state, the job queue and the multiply register to the output queue.
// Input is held off (full) until the sequencer is back in idle: a new item waits for the line-buffer
//   read and write-back pair and for its jobs, pushed one per cycle while the job queue has room.
// An early flush is taken and dropped without leaving idle. Output queue of 4 words decouples the consumer.
// Reset (synchronous, active low) sets 1024 x 1, position 0 and empties the queues;
//   line buffers are not cleared and need no clearing pass.
module box_blur_3x3_clamped #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  bbc_pkg::t_item                      i_item,
    output logic                                empty,
    input  logic                                pop,
    output bbc_pkg::t_result                    o_result,
    input  logic                                i_cfg_we,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bbc_pkg::CFG_D_W-1:0]         i_cfg_data
);

    localparam int CW = $clog2(bbc_pkg::QUEUE_DEPTH + 1);

    bbc_pkg::t_cfg_wr cfg;
    logic             job_push;
    bbc_pkg::t_job    job_in;
    bbc_pkg::t_job    job_out;
    logic             job_full;
    logic             job_empty;
    logic [CW-1:0]    job_count;
    logic             job_pop;
    logic             out_push;
    bbc_pkg::t_result out_word;
    logic             out_full;
    logic [CW-1:0]    out_count;

    assign cfg = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};

    // front: position, line buffers, window column sums
    bbc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    // job queue between front and back
    bbc_fifo #(
        .WIDTH ($bits(bbc_pkg::t_job)),
        .DEPTH (bbc_pkg::QUEUE_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty),
        .o_full  (job_full),
        .o_count (job_count)
    );

    // back: rounded division by the window size
    bbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_valid (!job_empty),
        .o_job_pop   (job_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_result    (out_word)
    );

    // result queue
    bbc_fifo #(
        .WIDTH ($bits(bbc_pkg::t_result)),
        .DEPTH (bbc_pkg::QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_word),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty),
        .o_full  (out_full),
        .o_count (out_count)
    );

`ifndef ASSERT_OFF
    // the job queue fill count and its full flag agree
    a_job_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_full == (job_count == CW'(bbc_pkg::QUEUE_DEPTH)))
        else $error("job queue full flag disagrees with count");
    // the back never lets the result queue fill past its room
    a_out_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_full |-> !out_push)
        else $error("result word pushed into full queue");
`endif

endmodule

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW          = 1024;
    localparam int MAXH          = 4096;
    localparam int SETTLE        = 40;     // cycles after the last result before a register write
    localparam int MAX_SHOWN     = 10;
    localparam int RAND_WORDS    = 600;
    localparam int RESET_FLUSHES = 6;      // drain ticks sent into the frame left by reset
    localparam int TALL_ROWS     = 24;     // rows sent into the oversized-height frame

    // one row of the directed table: a register write or an input word
    typedef struct packed {
        logic                          is_cfg;
        logic [bbc_pkg::CFG_IDX_W-1:0] idx;
        logic [bbc_pkg::CFG_D_W-1:0]   data;
        bbc_pkg::t_item                word;
        logic                          typed;   // results written out below instead of predicted
        logic [1:0]                    n_exp;
        bbc_pkg::t_result              r0;
        bbc_pkg::t_result              r1;
    } t_step;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          push       = 1'b0;
    logic                          pop        = 1'b0;
    logic                          i_cfg_we   = 1'b0;
    logic [bbc_pkg::CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [bbc_pkg::CFG_D_W-1:0]   i_cfg_data = '0;
    bbc_pkg::t_item                i_item     = '0;
    logic                          full;
    logic                          empty;
    bbc_pkg::t_result              o_result;

    box_blur_3x3_clamped #(
        .MAX_WIDTH  (MAXW),
        .MAX_HEIGHT (MAXH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // blur predictor state
    logic [bbc_pkg::CFG_W_W-1:0] width_reg;
    logic [bbc_pkg::CFG_H_W-1:0] height_reg;
    bbc_pkg::t_rgb               line_above [MAXW];
    bbc_pkg::t_rgb               line_cur   [MAXW];
    bbc_pkg::t_rgb               win        [3][3];   // [column old..new][row top..bottom]
    int unsigned                 pos_row;
    int unsigned                 pos_col;

    bbc_pkg::t_result awaited_pixels [$];
    int unsigned      mismatches     = 0;
    int unsigned      checked        = 0;
    int unsigned      frame_ends     = 0;
    int unsigned      accepted_words = 0;
    int unsigned      early_flushes  = 0;
    int unsigned      extra_pixels   = 0;
    int unsigned      reg_writes     = 0;
    int unsigned      burst_left     = 0;
    int unsigned      rx_cycle       = 0;
    int unsigned      rx_mode        = 0;

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAXW) return MAXW;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > MAXH) return MAXH;
        return height_reg;
    endfunction

    function automatic logic [bbc_pkg::CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic bbc_pkg::t_item rand_word(logic cmd);
        bbc_pkg::t_item w;
        w.cmd      = cmd;
        w.red_in   = rand_chan();
        w.green_in = rand_chan();
        w.blue_in  = rand_chan();
        return w;
    endfunction

    function automatic t_step mk_cfg(logic [bbc_pkg::CFG_IDX_W-1:0] idx,
                                     logic [bbc_pkg::CFG_D_W-1:0] data);
        t_step s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    function automatic t_step mk_word(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_step s;
        s      = '0;
        s.word = '{cmd: cmd, red_in: r, green_in: g, blue_in: b};
        return s;
    endfunction

    function automatic t_step with_exp(t_step s, logic [1:0] n, bbc_pkg::t_result r0,
                                       bbc_pkg::t_result r1);
        s.typed = 1'b1;
        s.n_exp = n;
        s.r0    = r0;
        s.r1    = r1;
        return s;
    endfunction

    // rounded mean over window columns lo..2 and rows rlo..rhi
    function automatic bbc_pkg::t_result window_mean(int lo, int rlo, int rhi, logic done);
        int unsigned      sr = 0, sg = 0, sb = 0, cnt = 0;
        bbc_pkg::t_result r;
        for (int p = lo; p <= 2; p++) begin
            for (int q = rlo; q <= rhi; q++) begin
                sr += win[p][q].r;
                sg += win[p][q].g;
                sb += win[p][q].b;
                cnt++;
            end
        end
        if (cnt == 0) cnt = 1;
        r.red_out    = 8'((sr + cnt / 2) / cnt);
        r.green_out  = 8'((sg + cnt / 2) / cnt);
        r.blue_out   = 8'((sb + cnt / 2) / cnt);
        r.frame_done = done;
        return r;
    endfunction

    task automatic restart_position();
        pos_row = 0;
        pos_col = 0;
        foreach (win[p, q]) win[p][q] = '0;
    endtask

    // one accepted word through the predictor; results optionally queued
    task automatic advance_blur(input bbc_pkg::t_item word_in, input logic queue_it);
        int unsigned   wd, ht, vr, vc;
        bbc_pkg::t_rgb incoming;
        logic          done;
        wd   = eff_width();
        ht   = eff_height();
        vr   = pos_row;
        vc   = pos_col;
        done = 1'b0;
        // flush before the frame is in: dropped
        if (word_in.cmd == bbc_pkg::CMD_FLUSH && vr < ht) begin
            early_flushes++;
            return;
        end
        accepted_words++;
        if (word_in.cmd == bbc_pkg::CMD_PIXEL && vr >= ht) extra_pixels++;
        if (vc >= wd) vc = wd - 1;
        incoming = (vr < ht) ? bbc_pkg::t_rgb'{word_in.red_in, word_in.green_in,
                                               word_in.blue_in} : '0;

        for (int q = 0; q < 3; q++) begin
            win[0][q] = win[1][q];
            win[1][q] = win[2][q];
        end
        win[2][0]      = line_above[vc];
        win[2][1]      = line_cur[vc];
        win[2][2]      = incoming;
        line_above[vc] = line_cur[vc];
        line_cur[vc]   = incoming;

        if (vr >= 1) begin
            if (vc >= 1 && queue_it)
                awaited_pixels.push_back(window_mean((vc >= 2) ? 0 : 1, (vr >= 2) ? 0 : 1,
                                                     (vr < ht) ? 2 : 1, 1'b0));
            if (vc == wd - 1) begin
                done = (vr == ht);
                if (queue_it)
                    awaited_pixels.push_back(window_mean((wd >= 2) ? 1 : 2, (vr >= 2) ? 0 : 1,
                                                         (vr < ht) ? 2 : 1, done));
            end
        end

        vc++;
        if (vc >= wd) begin
            vc = 0;
            vr++;
        end
        pos_row = vr;
        pos_col = vc;
        if (done) restart_position();
    endtask

    // sender: bursts with random gaps; push stays high between words of a burst
    task automatic push_word(input bbc_pkg::t_item word_in, input logic by_model);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push   <= 1'b1;
        i_item <= word_in;
        do @(posedge i_clk); while (full);
        advance_blur(word_in, by_model);
    endtask

    // stop sending, wait for every awaited word, then let the block go quiet
    task automatic drain_then_settle();
        push <= 1'b0;
        while (awaited_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bbc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bbc_pkg::CFG_D_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bbc_pkg::CFG_FRAME_WIDTH)
            width_reg = data[bbc_pkg::CFG_W_W-1:0];
        else
            height_reg = data[bbc_pkg::CFG_H_W-1:0];
        restart_position();
        reg_writes++;
        @(posedge i_clk);
    endtask

    // one frame: pixels, then a phantom row of flushes; noisy adds broken items
    task automatic send_frame(input int unsigned wd, input int unsigned ht,
                              input logic noisy, input logic cut);
        int unsigned npx;
        npx = wd * ht;
        if (cut) npx = $urandom_range(0, npx - 1);
        for (int unsigned k = 0; k < npx; k++) begin
            if (noisy && $urandom_range(0, 24) == 0)
                push_word(rand_word(bbc_pkg::CMD_FLUSH), 1'b1);
            if (noisy && $urandom_range(0, 199) == 0) drain_then_settle();
            push_word(rand_word(bbc_pkg::CMD_PIXEL), 1'b1);
        end
        if (!cut) begin
            for (int unsigned k = 0; k < wd; k++) begin
                if (noisy && $urandom_range(0, 14) == 0)
                    push_word(rand_word(bbc_pkg::CMD_PIXEL), 1'b1);   // data dropped while draining
                else
                    push_word(rand_word(bbc_pkg::CMD_FLUSH), 1'b1);
            end
        end
    endtask

    // result side: check the popped word, then pick the next pop on a shifting pattern
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (awaited_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result word: r=%02h g=%02h b=%02h done=%0d",
                             o_result.red_out, o_result.green_out, o_result.blue_out,
                             o_result.frame_done);
            end else begin
                if (o_result !== awaited_pixels[0]) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch %0d: exp %02h %02h %02h %0d got %02h %02h %02h %0d",
                                 checked, awaited_pixels[0].red_out,
                                 awaited_pixels[0].green_out, awaited_pixels[0].blue_out,
                                 awaited_pixels[0].frame_done, o_result.red_out,
                                 o_result.green_out, o_result.blue_out, o_result.frame_done);
                end
                if (awaited_pixels[0].frame_done) frame_ends++;
                void'(awaited_pixels.pop_front());
                checked++;
            end
        end
        rx_cycle++;
        if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= (rx_cycle % 5 == 0);
            default: pop <= (rx_cycle % 32 < 8);
        endcase
    end

    initial begin : stimulus
        t_step                       tab [$];
        int unsigned                 base, wd, ht, nfr, npx;
        logic [bbc_pkg::CFG_D_W-1:0] wdata, hdata;

        width_reg  = bbc_pkg::WIDTH_RESET;
        height_reg = bbc_pkg::HEIGHT_RESET;
        foreach (line_above[i]) begin
            line_above[i] = '0;
            line_cur[i]   = '0;
        end
        restart_position();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sizes out of reset: fill the 1024 x 1 frame, then drain its first columns
        npx = eff_width() * eff_height();
        for (int unsigned k = 0; k < npx; k++)
            push_word(rand_word(bbc_pkg::CMD_PIXEL), 1'b1);
        for (int unsigned k = 0; k < RESET_FLUSHES; k++)
            push_word(rand_word(bbc_pkg::CMD_FLUSH), 1'b1);

        // directed: zero sizes, 1x1 frames, a 2x1 frame with half-up rounding, a 3x3 frame
        tab.push_back(mk_cfg(bbc_pkg::CFG_FRAME_WIDTH, 13'd0));
        tab.push_back(mk_cfg(bbc_pkg::CFG_FRAME_HEIGHT, 13'd0));
        tab.push_back(with_exp(mk_word(bbc_pkg::CMD_FLUSH, 8'haa, 8'h55, 8'h0f), 2'd0, '0, '0));
        tab.push_back(with_exp(mk_word(bbc_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'h80), 2'd0, '0, '0));
        tab.push_back(with_exp(mk_word(bbc_pkg::CMD_FLUSH, 8'h00, 8'hff, 8'hf0), 2'd1,
                               bbc_pkg::t_result'{8'hff, 8'h00, 8'h80, 1'b1}, '0));
        tab.push_back(with_exp(mk_word(bbc_pkg::CMD_PIXEL, 8'h00, 8'hff, 8'h7f), 2'd0, '0, '0));
        // a pixel in the phantom row acts as the flush
        tab.push_back(with_exp(mk_word(bbc_pkg::CMD_PIXEL, 8'h12, 8'h34, 8'h56), 2'd1,
                               bbc_pkg::t_result'{8'h00, 8'hff, 8'h7f, 1'b1}, '0));
        tab.push_back(mk_cfg(bbc_pkg::CFG_FRAME_WIDTH, 13'd2));
        tab.push_back(mk_cfg(bbc_pkg::CFG_FRAME_HEIGHT, 13'd1));
        tab.push_back(with_exp(mk_word(bbc_pkg::CMD_PIXEL, 8'hff, 8'h01, 8'hfe), 2'd0, '0, '0));
        tab.push_back(with_exp(mk_word(bbc_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'hff), 2'd0, '0, '0));
        tab.push_back(with_exp(mk_word(bbc_pkg::CMD_FLUSH, 8'hff, 8'hff, 8'hff), 2'd0, '0, '0));
        tab.push_back(with_exp(mk_word(bbc_pkg::CMD_FLUSH, 8'h00, 8'h00, 8'h00), 2'd2,
                               bbc_pkg::t_result'{8'h80, 8'h01, 8'hff, 1'b0},
                               bbc_pkg::t_result'{8'h80, 8'h01, 8'hff, 1'b1}));
        // upper data bits lie outside the width register
        tab.push_back(mk_cfg(bbc_pkg::CFG_FRAME_WIDTH, 13'h1803));
        tab.push_back(mk_cfg(bbc_pkg::CFG_FRAME_HEIGHT, 13'd3));
        tab.push_back(mk_word(bbc_pkg::CMD_PIXEL, 8'd10, 8'd20, 8'd30));
        tab.push_back(mk_word(bbc_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255));
        tab.push_back(mk_word(bbc_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd0));
        tab.push_back(mk_word(bbc_pkg::CMD_PIXEL, 8'd200, 8'd100, 8'd50));
        tab.push_back(mk_word(bbc_pkg::CMD_PIXEL, 8'd1, 8'd2, 8'd3));
        tab.push_back(with_exp(mk_word(bbc_pkg::CMD_FLUSH, 8'h5a, 8'ha5, 8'h3c), 2'd0, '0, '0));
        tab.push_back(mk_word(bbc_pkg::CMD_PIXEL, 8'd255, 8'd0, 8'd255));
        tab.push_back(mk_word(bbc_pkg::CMD_PIXEL, 8'd128, 8'd128, 8'd128));
        tab.push_back(mk_word(bbc_pkg::CMD_PIXEL, 8'd7, 8'd77, 8'd177));
        tab.push_back(mk_word(bbc_pkg::CMD_PIXEL, 8'd99, 8'd0, 8'd255));
        tab.push_back(mk_word(bbc_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0));
        tab.push_back(mk_word(bbc_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0));
        tab.push_back(mk_word(bbc_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0));

        foreach (tab[i]) begin
            if (tab[i].is_cfg) begin
                drain_then_settle();
                write_reg(tab[i].idx, tab[i].data);
            end else begin
                push_word(tab[i].word, !tab[i].typed);
                if (tab[i].typed && tab[i].n_exp >= 1) awaited_pixels.push_back(tab[i].r0);
                if (tab[i].typed && tab[i].n_exp >= 2) awaited_pixels.push_back(tab[i].r1);
            end
        end

        // random: small frames, back to back, with noise and cut-off frames
        base = accepted_words;
        while (accepted_words - base < RAND_WORDS) begin
            drain_then_settle();
            case ($urandom_range(0, 9))
                0:       wd = 0;
                9:       wd = $urandom_range(9, 40);
                default: wd = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       ht = 0;
                9:       ht = $urandom_range(6, 12);
                default: ht = $urandom_range(1, 5);
            endcase
            wdata = {2'($urandom_range(0, 3)), 11'(wd)};
            hdata = 13'(ht);
            if ($urandom_range(0, 1)) begin
                write_reg(bbc_pkg::CFG_FRAME_WIDTH, wdata);
                write_reg(bbc_pkg::CFG_FRAME_HEIGHT, hdata);
            end else begin
                write_reg(bbc_pkg::CFG_FRAME_HEIGHT, hdata);
                write_reg(bbc_pkg::CFG_FRAME_WIDTH, wdata);
            end
            nfr = $urandom_range(1, 3);
            for (int unsigned f = 0; f < nfr; f++)
                send_frame(eff_width(), eff_height(), 1'b1,
                           (f == nfr - 1) && ($urandom_range(0, 14) == 0));
        end

        // oversized height register on a one-pixel-wide frame: rows keep full windows
        drain_then_settle();
        write_reg(bbc_pkg::CFG_FRAME_WIDTH, 13'd1);
        write_reg(bbc_pkg::CFG_FRAME_HEIGHT, 13'h1fff);
        for (int unsigned k = 0; k < TALL_ROWS; k++)
            push_word(rand_word(bbc_pkg::CMD_PIXEL), 1'b1);

        drain_then_settle();
        $display("checked %0d output words from %0d accepted input words, %0d frame ends",
                 checked, accepted_words, frame_ends);
        $display("dropped flushes %0d, pixels in drain row %0d, register writes %0d",
                 early_flushes, extra_pixels, reg_writes);
        if (mismatches == 0 && awaited_pixels.size() == 0) begin
            $display("[box_blur_3x3_clamped] OK");
        end else begin
            $display("[box_blur_3x3_clamped] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("timeout with %0d words still awaited", awaited_pixels.size());
        $display("[box_blur_3x3_clamped] ERROR");
        $finish;
    end

endmodule
